FILE: hdl/cea_pkg.sv
// Shared widths, operation codes, lane type and saturation for the complex ALU.
package cea_pkg;

  localparam int DW    = 32;
  localparam int FB    = 16;
  localparam int PW    = 2 * DW;
  localparam int SW    = PW + 1;
  localparam int XW    = SW + 1;
  localparam int DDW   = PW + 2;
  localparam int NW    = PW + FB + 3;
  localparam int HW    = NW - DW;
  localparam int NCELL = DW;

  typedef logic signed [DW-1:0] data_t;

  typedef enum logic [2:0] {
    F_ADD  = 3'd0,
    F_SUB  = 3'd1,
    F_MUL  = 3'd2,
    F_DIV  = 3'd3,
    F_NEG  = 3'd4,
    F_CONJ = 3'd5,
    F_SQR  = 3'd6
  } func_t;

  typedef struct packed {
    data_t v;
    logic  f;
  } sat_t;

  typedef struct packed {
    logic           is_div;
    logic           dz;
    logic           neg_re;
    logic           neg_im;
    logic           ovf_re;
    logic           ovf_im;
    logic [DDW-1:0] d;
    logic [DDW-1:0] r_re;
    logic [DDW-1:0] r_im;
    logic [DW-1:0]  x_re;
    logic [DW-1:0]  x_im;
    data_t          res_re;
    data_t          res_im;
    logic           sat;
  } lane_t;

  localparam data_t DMAX = {1'b0, {(DW-1){1'b1}}};
  localparam data_t DMIN = {1'b1, {(DW-1){1'b0}}};

  function automatic sat_t saturate(input logic signed [XW-1:0] x);
    sat_t s;
    logic signed [XW-1:0] mx;
    logic signed [XW-1:0] mn;
    mx = {{(XW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    mn = {{(XW-DW+1){1'b1}}, {(DW-1){1'b0}}};
    if (x > mx) begin
      s.v = DMAX;
      s.f = 1'b1;
    end else if (x < mn) begin
      s.v = DMIN;
      s.f = 1'b1;
    end else begin
      s.v = x[DW-1:0];
      s.f = 1'b0;
    end
    return s;
  endfunction

endpackage

FILE: hdl/cea_if.sv
// Input and result channel interfaces of the complex ALU.
interface cea_in_if;
  import cea_pkg::*;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  data_t       a_re;
  data_t       a_im;
  data_t       b_re;
  data_t       b_im;
  modport source(output valid, func, a_re, a_im, b_re, b_im, input ready);
  modport sink(input valid, func, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cea_out_if;
  import cea_pkg::*;
  logic  valid;
  logic  ready;
  data_t res_re;
  data_t res_im;
  logic  div_zero;
  logic  saturated;
  modport source(output valid, res_re, res_im, div_zero, saturated, input ready);
  modport sink(input valid, res_re, res_im, div_zero, saturated, output ready);
endinterface

FILE: hdl/complex_elementwise_alu.sv
// Top level of the complex ALU: front stages, divider cell chain, output stage.
// Pipeline from input transaction to result: 3 front stages, 32 cells, 1 output.
// Throughput: one transaction per cycle for every operation when not stalled; each
// divider cell develops one quotient bit, so the 32-bit quotient sets chain length.
// Stages hold under backpressure and empty stages fill while later ones wait.
// Reset: synchronous active-low rst_n clears all valid bits; data is not reset.
module complex_elementwise_alu (
  input  logic       clk,
  input  logic       rst_n,
  cea_in_if.sink     in_ch,
  cea_out_if.source  out_ch
);
  import cea_pkg::*;

  lane_t lanes [NCELL+1];
  logic  lv    [NCELL+1];
  logic  lrdy  [NCELL+1];

  cea_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .lane_o    (lanes[0]),
    .lane_v_o  (lv[0]),
    .lane_rdy_i(lrdy[0])
  );

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    cea_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .lane_i(lanes[i]),
      .v_i   (lv[i]),
      .rdy_o (lrdy[i]),
      .lane_o(lanes[i+1]),
      .v_o   (lv[i+1]),
      .rdy_i (lrdy[i+1])
    );
  end

  cea_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .lane_i(lanes[NCELL]),
    .v_i   (lv[NCELL]),
    .rdy_o (lrdy[NCELL]),
    .out_ch(out_ch)
  );

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.div_zero |->
      out_ch.res_re == '0 && out_ch.res_im == '0 && !out_ch.saturated)
    else $error("zero divisor result not cleared");

  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.saturated |->
      out_ch.res_re == DMAX || out_ch.res_re == DMIN ||
      out_ch.res_im == DMAX || out_ch.res_im == DMIN)
    else $error("saturation flag without clipped part");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid && !out_ch.ready)
    else $error("input stalled while output not blocked");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    lv[NCELL] && lrdy[NCELL] |=> out_ch.valid)
    else $error("result lost at output stage");

endmodule

FILE: hdl/cea_front.sv
// Front stages: products, sums and rounding, divider lane setup.
module cea_front (
  input  logic          clk,
  input  logic          rst_n,
  cea_in_if.sink        in_ch,
  output cea_pkg::lane_t lane_o,
  output logic          lane_v_o,
  input  logic          lane_rdy_i
);
  import cea_pkg::*;

  localparam logic signed [XW-1:0] HALF = (XW'(1) << FB) >> 1;

  logic a_v_r, b_v_r, c_v_r;
  logic a_rdy, b_rdy, c_rdy;

  func_t                 f_in;
  data_t                 op_ar, op_ai;
  logic signed [DW:0]    s_re, s_im;
  func_t                 func_a_r, func_b_r;
  logic signed [PW-1:0]  prr_r, pii_r, pri_r, pir_r, pbr_r, pbi_r;
  sat_t                  sim_re_r, sim_im_r;

  logic signed [SW-1:0]  m_re, m_im, nr, ni;
  logic signed [XW-1:0]  rd_re, rd_im;
  logic signed [SW-1:0]  num_re_r, num_im_r;
  logic [SW-1:0]         den_r;
  sat_t                  res_re_r, res_im_r;

  logic [SW-1:0]         mag_re, mag_im;
  logic [NW-1:0]         n_re, n_im;
  logic [DDW-1:0]        d_c;
  lane_t                 lane_nxt, lane_r;

  assign c_rdy       = !c_v_r || lane_rdy_i;
  assign b_rdy       = !b_v_r || c_rdy;
  assign a_rdy       = !a_v_r || b_rdy;
  assign in_ch.ready = a_rdy;

  always_comb begin
    f_in  = func_t'(in_ch.func);
    op_ar = (f_in == F_SQR) ? in_ch.b_re : in_ch.a_re;
    op_ai = (f_in == F_SQR) ? in_ch.b_im : in_ch.a_im;
    s_re  = '0;
    s_im  = '0;
    case (f_in)
      F_ADD: begin
        s_re = {in_ch.a_re[DW-1], in_ch.a_re} + {in_ch.b_re[DW-1], in_ch.b_re};
        s_im = {in_ch.a_im[DW-1], in_ch.a_im} + {in_ch.b_im[DW-1], in_ch.b_im};
      end
      F_SUB: begin
        s_re = {in_ch.a_re[DW-1], in_ch.a_re} - {in_ch.b_re[DW-1], in_ch.b_re};
        s_im = {in_ch.a_im[DW-1], in_ch.a_im} - {in_ch.b_im[DW-1], in_ch.b_im};
      end
      F_NEG: begin
        s_re = -{in_ch.b_re[DW-1], in_ch.b_re};
        s_im = -{in_ch.b_im[DW-1], in_ch.b_im};
      end
      F_CONJ: begin
        s_re = {in_ch.b_re[DW-1], in_ch.b_re};
        s_im = -{in_ch.b_im[DW-1], in_ch.b_im};
      end
      default: begin
        s_re = '0;
        s_im = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (a_rdy) begin
      a_v_r <= in_ch.valid;
    end
    if (a_rdy && in_ch.valid) begin
      func_a_r <= f_in;
      prr_r    <= op_ar * in_ch.b_re;
      pii_r    <= op_ai * in_ch.b_im;
      pri_r    <= op_ar * in_ch.b_im;
      pir_r    <= op_ai * in_ch.b_re;
      pbr_r    <= in_ch.b_re * in_ch.b_re;
      pbi_r    <= in_ch.b_im * in_ch.b_im;
      sim_re_r <= saturate({{(XW-DW-1){s_re[DW]}}, s_re});
      sim_im_r <= saturate({{(XW-DW-1){s_im[DW]}}, s_im});
    end
  end

  always_comb begin
    m_re  = {prr_r[PW-1], prr_r} - {pii_r[PW-1], pii_r};
    m_im  = {pri_r[PW-1], pri_r} + {pir_r[PW-1], pir_r};
    nr    = {prr_r[PW-1], prr_r} + {pii_r[PW-1], pii_r};
    ni    = {pir_r[PW-1], pir_r} - {pri_r[PW-1], pri_r};
    rd_re = ($signed({m_re[SW-1], m_re}) + HALF) >>> FB;
    rd_im = ($signed({m_im[SW-1], m_im}) + HALF) >>> FB;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (b_rdy) begin
      b_v_r <= a_v_r;
    end
    if (b_rdy && a_v_r) begin
      func_b_r <= func_a_r;
      num_re_r <= nr;
      num_im_r <= ni;
      den_r    <= {1'b0, pbr_r} + {1'b0, pbi_r};
      if (func_a_r == F_MUL || func_a_r == F_SQR) begin
        res_re_r <= saturate(rd_re);
        res_im_r <= saturate(rd_im);
      end else begin
        res_re_r <= sim_re_r;
        res_im_r <= sim_im_r;
      end
    end
  end

  always_comb begin
    mag_re          = num_re_r[SW-1] ? SW'(-num_re_r) : SW'(num_re_r);
    mag_im          = num_im_r[SW-1] ? SW'(-num_im_r) : SW'(num_im_r);
    n_re            = {1'b0, mag_re, {(FB+1){1'b0}}} + {{(NW-SW){1'b0}}, den_r};
    n_im            = {1'b0, mag_im, {(FB+1){1'b0}}} + {{(NW-SW){1'b0}}, den_r};
    d_c             = {den_r, 1'b0};
    lane_nxt.is_div = (func_b_r == F_DIV);
    lane_nxt.dz     = (func_b_r == F_DIV) && (den_r == '0);
    lane_nxt.neg_re = num_re_r[SW-1];
    lane_nxt.neg_im = num_im_r[SW-1];
    lane_nxt.ovf_re = {{(DDW-HW){1'b0}}, n_re[NW-1:DW]} >= d_c;
    lane_nxt.ovf_im = {{(DDW-HW){1'b0}}, n_im[NW-1:DW]} >= d_c;
    lane_nxt.d      = d_c;
    lane_nxt.r_re   = {{(DDW-HW){1'b0}}, n_re[NW-1:DW]};
    lane_nxt.r_im   = {{(DDW-HW){1'b0}}, n_im[NW-1:DW]};
    lane_nxt.x_re   = n_re[DW-1:0];
    lane_nxt.x_im   = n_im[DW-1:0];
    lane_nxt.res_re = res_re_r.v;
    lane_nxt.res_im = res_im_r.v;
    lane_nxt.sat    = res_re_r.f || res_im_r.f;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (c_rdy) begin
      c_v_r <= b_v_r;
    end
    if (c_rdy && b_v_r) begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_o   = lane_r;
  assign lane_v_o = c_v_r;

endmodule

FILE: hdl/cea_div_cell.sv
// One divider cell: develops one quotient bit of both parts and passes the lane on.
module cea_div_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  cea_pkg::lane_t lane_i,
  input  logic           v_i,
  output logic           rdy_o,
  output cea_pkg::lane_t lane_o,
  output logic           v_o,
  input  logic           rdy_i
);
  import cea_pkg::*;

  logic [DDW:0] t_re, t_im, dx;
  logic         ge_re, ge_im;
  lane_t        lane_nxt, lane_r;
  logic         v_r;

  assign rdy_o = !v_r || rdy_i;

  always_comb begin
    lane_nxt      = lane_i;
    dx            = {1'b0, lane_i.d};
    t_re          = {lane_i.r_re, lane_i.x_re[DW-1]};
    t_im          = {lane_i.r_im, lane_i.x_im[DW-1]};
    ge_re         = t_re >= dx;
    ge_im         = t_im >= dx;
    lane_nxt.r_re = ge_re ? DDW'(t_re - dx) : t_re[DDW-1:0];
    lane_nxt.r_im = ge_im ? DDW'(t_im - dx) : t_im[DDW-1:0];
    lane_nxt.x_re = {lane_i.x_re[DW-2:0], ge_re};
    lane_nxt.x_im = {lane_i.x_im[DW-2:0], ge_im};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy_o) begin
      v_r <= v_i;
    end
    if (rdy_o && v_i) begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_o = lane_r;
  assign v_o    = v_r;

endmodule

FILE: hdl/cea_back.sv
// Output stage: quotient sign and saturation, zero-divisor override, result register.
module cea_back (
  input  logic           clk,
  input  logic           rst_n,
  input  cea_pkg::lane_t lane_i,
  input  logic           v_i,
  output logic           rdy_o,
  cea_out_if.source      out_ch
);
  import cea_pkg::*;

  function automatic sat_t fin(input logic [DW-1:0] q, input logic neg, input logic ovf);
    sat_t s;
    if (!neg) begin
      if (ovf || q[DW-1]) begin
        s.v = DMAX;
        s.f = 1'b1;
      end else begin
        s.v = q;
        s.f = 1'b0;
      end
    end else begin
      if (ovf || (q > DMIN)) begin
        s.v = DMIN;
        s.f = 1'b1;
      end else begin
        s.v = -q;
        s.f = 1'b0;
      end
    end
    return s;
  endfunction

  sat_t  q_re, q_im;
  logic  v_r;
  data_t re_r, im_r, re_nxt, im_nxt;
  logic  dz_r, sat_r, dz_nxt, sat_nxt;

  assign rdy_o = !v_r || out_ch.ready;

  always_comb begin
    q_re    = fin(lane_i.x_re, lane_i.neg_re, lane_i.ovf_re);
    q_im    = fin(lane_i.x_im, lane_i.neg_im, lane_i.ovf_im);
    re_nxt  = lane_i.res_re;
    im_nxt  = lane_i.res_im;
    dz_nxt  = 1'b0;
    sat_nxt = lane_i.sat;
    if (lane_i.is_div) begin
      if (lane_i.dz) begin
        re_nxt  = '0;
        im_nxt  = '0;
        dz_nxt  = 1'b1;
        sat_nxt = 1'b0;
      end else begin
        re_nxt  = q_re.v;
        im_nxt  = q_im.v;
        sat_nxt = q_re.f || q_im.f;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy_o) begin
      v_r <= v_i;
    end
    if (rdy_o && v_i) begin
      re_r  <= re_nxt;
      im_r  <= im_nxt;
      dz_r  <= dz_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign out_ch.valid     = v_r;
  assign out_ch.res_re    = re_r;
  assign out_ch.res_im    = im_r;
  assign out_ch.div_zero  = dz_r;
  assign out_ch.saturated = sat_r;

endmodule
